// ===== rtl/lrmb_pkg.sv =====
// lrmb_pkg: shared sizes, codes and types of the low-rank matmul block
// no dependencies; imported by every module of the block
package lrmb_pkg;

    localparam int D_MAX  = 64;
    localparam int K_MAX  = 16;
    localparam int N_MAX  = 64;

    localparam int IDX_W  = 6;                  // row / column index
    localparam int RANK_W = 4;                  // factor column index
    localparam int CNT_W  = RANK_W + 1;         // counts 0..K_MAX
    localparam int DIM_W  = 7;                  // dimension registers
    localparam int VAL_W  = 16;                 // q4.12 operands
    localparam int ADDR_W = IDX_W + RANK_W;     // factor table address
    localparam int ACC_W  = 40;                 // projection accumulators
    localparam int FRAC_W = 12;
    localparam int T_W    = ACC_W - FRAC_W;     // projection after shift, never clips
    localparam int PROD_W = T_W + VAL_W;        // shared multiplier output
    localparam int SUM_W  = PROD_W + RANK_W;    // column dot product
    localparam int RES_W  = 32;
    localparam int ZW_W   = SUM_W - FRAC_W + 1; // shifted sum plus bias

    typedef enum logic [1:0] {
        FUNC_WR_U    = 2'd0,
        FUNC_WR_V    = 2'd1,
        FUNC_WR_BIAS = 2'd2,
        FUNC_X       = 2'd3
    } t_func;

    localparam logic [1:0] REG_DIM_IN   = 2'd0;
    localparam logic [1:0] REG_RANK     = 2'd1;
    localparam logic [1:0] REG_DIM_OUT  = 2'd2;
    localparam logic [1:0] REG_BIAS_EN  = 2'd3;

    typedef struct packed {
        t_func                    func;
        logic [IDX_W-1:0]         idx;
        logic [RANK_W-1:0]        rank;
        logic signed [VAL_W-1:0]  val;
        logic                     accum;   // x element inside dim_in
        logic                     last;    // x element that ends the row
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0] dim_in;
        logic [CNT_W-1:0] rank_k;   // clamped to K_MAX
        logic [DIM_W-1:0] cols_n;   // clamped to N_MAX
        logic             bias_en;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_MAC,
        ST_PROJ,
        ST_COL,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/lrmb_front.sv =====
// lrmb_front: accepts input transactions, classifies them and queues commands
// depends on lrmb_pkg
module lrmb_front import lrmb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_func,
    input  logic [IDX_W-1:0]        i_elem_index,
    input  logic [RANK_W-1:0]       i_rank_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_row_end,
    input  logic [DIM_W-1:0]        i_dim_in,
    input  logic                    i_pop,
    output logic                    o_q_valid,
    output t_cmd                    o_q_head
);

    t_cmd       cmd;
    logic       keep;
    logic       push;
    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    // classify: x elements past dim_in that do not end a row are dropped
    always_comb begin
        cmd.func  = t_func'(i_func);
        cmd.idx   = i_elem_index;
        cmd.rank  = i_rank_index;
        cmd.val   = i_value;
        cmd.accum = (cmd.func == FUNC_X) && ({1'b0, i_elem_index} < i_dim_in);
        cmd.last  = (cmd.func == FUNC_X) && i_row_end;
        keep      = (cmd.func != FUNC_X) || cmd.accum || cmd.last;
    end

    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_head  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

// ===== rtl/lrmb_back.sv =====
// lrmb_back: factor and bias tables, shared multiplier, accumulators, result register
// depends on lrmb_pkg
module lrmb_back import lrmb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_valid,
    input  t_cmd                    i_q_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [RES_W-1:0] o_result,
    output logic [IDX_W-1:0]        o_out_col,
    output logic                    o_row_last,
    output logic                    o_saturated
);

    t_state                    r_state, n_state;
    t_cmd                      r_cmd;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_p1_vld, r_p2_vld;
    logic [RANK_W-1:0]         r_p1_rank, r_p2_rank;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc [K_MAX];
    logic signed [T_W-1:0]     r_t [K_MAX];
    logic                      r_proj_sat;
    logic signed [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]          r_col;

    logic signed [VAL_W-1:0]   r_u_mem [D_MAX*K_MAX];
    logic signed [VAL_W-1:0]   r_v_mem [N_MAX*K_MAX];
    logic signed [VAL_W-1:0]   r_bias_mem [N_MAX];
    logic signed [VAL_W-1:0]   r_u_rd, r_v_rd, r_bias_rd;

    logic                      r_o_valid;
    logic signed [RES_W-1:0]   r_o_result;
    logic [IDX_W-1:0]          r_o_col;
    logic                      r_o_last, r_o_sat;

    logic                      issue, phase_done, out_free, emit, col_last;
    logic                      we_u, we_v, we_bias;
    logic signed [T_W-1:0]     mul_a;
    logic signed [VAL_W-1:0]   mul_b;
    logic signed [ACC_W:0]     acc_sum;
    logic                      acc_ovf;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ZW_W-1:0]    z_wide;
    logic                      z_clip;
    logic signed [RES_W-1:0]   z_sat;

    // ---------------- control ----------------
    always_comb begin
        out_free   = !r_o_valid || i_ready;
        issue      = ((r_state == ST_MAC) || (r_state == ST_COL)) && (r_cnt < i_cfg.rank_k);
        phase_done = (r_cnt >= i_cfg.rank_k) && !r_p1_vld && !r_p2_vld;
        col_last   = ({1'b0, r_col} == (i_cfg.cols_n - DIM_W'(1)));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_head.func != FUNC_X) begin
                        n_state = ST_WR;
                    end else if (i_q_head.accum) begin
                        n_state = ST_MAC;
                    end else begin
                        n_state = ST_PROJ;
                    end
                end
            end
            ST_WR:   n_state = ST_IDLE;
            ST_MAC: begin
                if (phase_done) begin
                    n_state = r_cmd.last ? ST_PROJ : ST_IDLE;
                end
            end
            ST_PROJ: n_state = (i_cfg.cols_n == '0) ? ST_IDLE : ST_COL;
            ST_COL: begin
                if (phase_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = col_last ? ST_IDLE : ST_COL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == ST_IDLE) && i_q_valid;
        emit    = (r_state == ST_EMIT) && out_free;
        we_u    = (r_state == ST_WR) && (r_cmd.func == FUNC_WR_U);
        we_v    = (r_state == ST_WR) && (r_cmd.func == FUNC_WR_V);
        we_bias = (r_state == ST_WR) && (r_cmd.func == FUNC_WR_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- tables ----------------
    always_ff @(posedge i_clk) begin
        if (we_u) begin
            r_u_mem[{r_cmd.idx, r_cmd.rank}] <= r_cmd.val;
        end
        r_u_rd <= r_u_mem[{r_cmd.idx, r_cnt[RANK_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (we_v) begin
            r_v_mem[{r_cmd.idx, r_cmd.rank}] <= r_cmd.val;
        end
        r_v_rd <= r_v_mem[{r_col, r_cnt[RANK_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (we_bias) begin
            r_bias_mem[r_cmd.idx] <= r_cmd.val;
        end
        r_bias_rd <= r_bias_mem[r_col];
    end

    // ---------------- shared multiply pipeline ----------------
    always_comb begin
        mul_a = (r_state == ST_COL) ? r_t[r_p1_rank] : T_W'(r_cmd.val);
        mul_b = (r_state == ST_COL) ? r_v_rd : r_u_rd;
    end

    always_comb begin
        acc_sum  = ACC_W'(r_acc[r_p2_rank]) + (ACC_W+1)'(r_prod);
        acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];
        acc_next = acc_ovf ? {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}}
                           : acc_sum[ACC_W-1:0];
    end

    // result: shift the dot product, add the bias when bias_en is set, clip to 32 bits
    always_comb begin
        z_wide = ZW_W'(r_sum >>> FRAC_W);
        if (i_cfg.bias_en) begin
            z_wide = z_wide + ZW_W'(r_bias_rd);
        end
        z_clip = (z_wide[ZW_W-1:RES_W-1] != '0) && (z_wide[ZW_W-1:RES_W-1] != '1);
        z_sat  = z_clip ? {z_wide[ZW_W-1], {(RES_W-1){~z_wide[ZW_W-1]}}}
                        : z_wide[RES_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_head;
        end
        r_p1_rank <= r_cnt[RANK_W-1:0];
        r_p2_rank <= r_p1_rank;
        r_prod    <= mul_a * mul_b;
        if (r_state == ST_PROJ) begin
            for (int i = 0; i < K_MAX; i++) begin
                r_t[i] <= (CNT_W'(i) < i_cfg.rank_k) ? T_W'(r_acc[i] >>> FRAC_W) : '0;
            end
        end
        if ((r_state == ST_PROJ) || emit) begin
            r_sum <= '0;
        end else if ((r_state == ST_COL) && r_p2_vld) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
        if (r_state == ST_PROJ) begin
            r_col <= '0;
        end else if (emit) begin
            r_col <= r_col + IDX_W'(1);
        end
        if (emit) begin
            r_o_result <= z_sat;
            r_o_col    <= r_col;
            r_o_last   <= col_last;
            r_o_sat    <= r_proj_sat || z_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_proj_sat <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < K_MAX; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            if (o_pop || (r_state == ST_PROJ) || emit) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == ST_PROJ) begin
                for (int i = 0; i < K_MAX; i++) begin
                    r_acc[i] <= '0;
                end
            end else if ((r_state == ST_MAC) && r_p2_vld) begin
                r_acc[r_p2_rank] <= acc_next;
            end
            if ((r_state == ST_MAC) && r_p2_vld && acc_ovf) begin
                r_proj_sat <= 1'b1;
            end else if ((emit && col_last) ||
                         ((r_state == ST_PROJ) && (i_cfg.cols_n == '0))) begin
                r_proj_sat <= 1'b0;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_result    = r_o_result;
    assign o_out_col   = r_o_col;
    assign o_row_last  = r_o_last;
    assign o_saturated = r_o_sat;

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(K_MAX))
        else $error("rank counter beyond K_MAX");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_p1_vld && !r_p2_vld))
        else $error("multiply pipeline busy in idle");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROJ) |=> (r_acc[0] == '0))
        else $error("accumulators not cleared after projection");

endmodule

// ===== rtl/low_rank_matmul_bias.sv =====
// low_rank_matmul_bias: top level, apb register file, front queue and back engine
// depends on lrmb_pkg, lrmb_front, lrmb_back
// row end: a projection step, then a dot product per column to its result; the single
// shared multiplier walks the rank for every x element and every column, and the back
// engine takes one command at a time, while the two-entry front queue keeps accepting
// items until it is full
// reset: synchronous active low, clears control and accumulators; tables
// hold garbage until written, registers return to 64 / 16 / 64 / 0
module low_rank_matmul_bias import lrmb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input transactions
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_func,
    input  logic [IDX_W-1:0]        i_elem_index,
    input  logic [RANK_W-1:0]       i_rank_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_row_end,
    // result transactions
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [RES_W-1:0] o_result,
    output logic [IDX_W-1:0]        o_out_col,
    output logic                    o_row_last,
    output logic                    o_saturated,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // configuration registers
    logic [DIM_W-1:0] r_dim_in;
    logic [CNT_W-1:0] r_rank_used;
    logic [DIM_W-1:0] r_dim_out;
    logic             r_bias_en;
    logic             cfg_wr;
    logic [1:0]       reg_sel;
    t_cfg             cfg;

    // queue between front and back
    logic q_valid;
    logic q_pop;
    t_cmd q_head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_in    <= DIM_W'(D_MAX);
            r_rank_used <= CNT_W'(K_MAX);
            r_dim_out   <= DIM_W'(N_MAX);
            r_bias_en   <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_DIM_IN:  r_dim_in    <= pwdata[DIM_W-1:0];
                REG_RANK:    r_rank_used <= pwdata[CNT_W-1:0];
                REG_DIM_OUT: r_dim_out   <= pwdata[DIM_W-1:0];
                REG_BIAS_EN: r_bias_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_DIM_IN:  prdata = 32'(r_dim_in);
            REG_RANK:    prdata = 32'(r_rank_used);
            REG_DIM_OUT: prdata = 32'(r_dim_out);
            REG_BIAS_EN: prdata = 32'(r_bias_en);
            default:     prdata = '0;
        endcase
    end

    // clamp rank and column count to what the tables hold
    always_comb begin
        cfg.dim_in  = r_dim_in;
        cfg.rank_k  = (r_rank_used > CNT_W'(K_MAX)) ? CNT_W'(K_MAX) : r_rank_used;
        cfg.cols_n  = (r_dim_out > DIM_W'(N_MAX)) ? DIM_W'(N_MAX) : r_dim_out;
        cfg.bias_en = r_bias_en;
    end

    // front: accepts, drops dead x elements, queues commands
    lrmb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_elem_index (i_elem_index),
        .i_rank_index (i_rank_index),
        .i_value      (i_value),
        .i_row_end    (i_row_end),
        .i_dim_in     (r_dim_in),
        .i_pop        (q_pop),
        .o_q_valid    (q_valid),
        .o_q_head     (q_head)
    );

    // back: table writes, projection mac, column dot products, result register
    lrmb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .o_out_col   (o_out_col),
        .o_row_last  (o_row_last),
        .o_saturated (o_saturated)
    );

endmodule

// ===== dv/lrmb_checker.sv =====
// lrmb_checker: watches the item, result and register channels of low_rank_matmul_bias
// keeps its own copy of tables, accumulators and settings; depends on lrmb_pkg
module lrmb_checker import lrmb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_func,
    input  logic [IDX_W-1:0]        i_elem_index,
    input  logic [RANK_W-1:0]       i_rank_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_row_end,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [RES_W-1:0] i_result,
    input  logic [IDX_W-1:0]        i_out_col,
    input  logic                    i_row_last,
    input  logic                    i_saturated,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic                    i_pready,
    input  logic [3:0]              i_paddr,
    input  logic [31:0]             i_pwdata,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_result_count
);

    localparam longint ACC_HI = 64'sh7F_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct {
        logic signed [RES_W-1:0] z;
        logic [IDX_W-1:0]        col;
        logic                    last;
        logic                    sat;
    } t_col_result;

    t_col_result             col_queue[$];
    logic signed [VAL_W-1:0] u_tab[D_MAX*K_MAX];
    logic signed [VAL_W-1:0] v_tab[N_MAX*K_MAX];
    logic signed [VAL_W-1:0] bias_tab[N_MAX];
    longint                  proj[K_MAX];
    bit                      proj_clip;
    logic [DIM_W-1:0]        set_din;
    logic [4:0]              set_rank;
    logic [DIM_W-1:0]        set_dout;
    logic                    set_bias;
    int                      fails;
    int                      n_results;

    assign o_fail_count   = fails;
    assign o_pending      = col_queue.size();
    assign o_result_count = n_results;

    function automatic longint clip32(input longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // low-rank row engine: table writes, accumulate projections, emit one row on row end
    task automatic lowrank_step(t_func f, int ix, int r, logic signed [VAL_W-1:0] v, bit last);
        int          k;
        int          d;
        int          n;
        longint      t[K_MAX];
        longint      s;
        longint      sum;
        longint      z;
        bit          clip;
        t_col_result e;
        k = (set_rank > K_MAX) ? K_MAX : int'(set_rank);
        d = (set_din > D_MAX) ? D_MAX : int'(set_din);
        n = (set_dout > 64) ? 64 : int'(set_dout);
        case (f)
            FUNC_WR_U:    u_tab[ix*K_MAX + r] = v;
            FUNC_WR_V:    v_tab[ix*K_MAX + r] = v;
            FUNC_WR_BIAS: bias_tab[ix] = v;
            default: begin
                if (ix < d) begin
                    for (int i = 0; i < k; i++) begin
                        s = proj[i] + longint'(v) * longint'(u_tab[ix*K_MAX + i]);
                        if (s > ACC_HI) begin
                            s = ACC_HI;
                            proj_clip = 1'b1;
                        end
                        if (s < ACC_LO) begin
                            s = ACC_LO;
                            proj_clip = 1'b1;
                        end
                        proj[i] = s;
                    end
                end
                if (last) begin
                    for (int i = 0; i < K_MAX; i++)
                        t[i] = (i < k) ? clip32(proj[i] >>> FRAC_W, proj_clip) : 0;
                    for (int c = 0; c < n; c++) begin
                        sum  = 0;
                        clip = proj_clip;
                        for (int i = 0; i < k; i++)
                            sum += t[i] * longint'(v_tab[c*K_MAX + i]);
                        z = sum >>> FRAC_W;
                        if (set_bias)
                            z += longint'(bias_tab[c]);
                        z      = clip32(z, clip);
                        e.z    = z[RES_W-1:0];
                        e.col  = c[IDX_W-1:0];
                        e.last = (c + 1 == n);
                        e.sat  = clip;
                        col_queue.push_back(e);
                    end
                    for (int i = 0; i < K_MAX; i++)
                        proj[i] = 0;
                    proj_clip = 1'b0;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_col_result e;
        if (!i_rst_n) begin
            col_queue.delete();
            for (int i = 0; i < K_MAX; i++)
                proj[i] = 0;
            proj_clip = 1'b0;
            set_din   = 7'd64;
            set_rank  = 5'd16;
            set_dout  = 7'd64;
            set_bias  = 1'b0;
            fails     = 0;
            n_results = 0;
        end else begin
            // result transaction against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                n_results++;
                if (col_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result z=%0d col=%0d", i_result, i_out_col);
                end else begin
                    e = col_queue.pop_front();
                    if (i_result !== e.z || i_out_col !== e.col ||
                        i_row_last !== e.last || i_saturated !== e.sat) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch exp z=%0d col=%0d last=%0b sat=%0b, got %0d %0d %0b %0b",
                                     e.z, e.col, e.last, e.sat,
                                     i_result, i_out_col, i_row_last, i_saturated);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_DIM_IN:  set_din  = i_pwdata[6:0];
                    REG_RANK:    set_rank = i_pwdata[4:0];
                    REG_DIM_OUT: set_dout = i_pwdata[6:0];
                    REG_BIAS_EN: set_bias = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                lowrank_step(t_func'(i_func), int'(i_elem_index), int'(i_rank_index),
                             i_value, i_row_end);
        end
    end

endmodule

// ===== dv/tb_low_rank_matmul_bias.sv =====
// tb_low_rank_matmul_bias: stimulus, handshake pacing and verdict for low_rank_matmul_bias
// depends on lrmb_pkg, the block rtl and lrmb_checker
module tb_low_rank_matmul_bias;
    import lrmb_pkg::*;

    localparam int WATCHDOG   = 20000;  // cycles with no transaction anywhere
    localparam int ROW_SETTLE = 1500;   // a 64-column row at full rank, plus margin
    localparam int LONG_HOLD  = 3000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [1:0]              i_func = FUNC_X;
    logic [IDX_W-1:0]        i_elem_index = '0;
    logic [RANK_W-1:0]       i_rank_index = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    i_row_end = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [RES_W-1:0] o_result;
    logic [IDX_W-1:0]        o_out_col;
    logic                    o_row_last;
    logic                    o_saturated;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [3:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    int fail_count;
    int pending;
    int result_count;
    int tx_idle_pct = 11;
    int rx_idle_pct = 45;
    int hold_left   = 0;
    int n_items     = 0;
    int n_settings  = 0;
    int quiet       = 0;

    always #10 i_clk = ~i_clk;

    low_rank_matmul_bias u_top (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_func, .i_elem_index, .i_rank_index, .i_value, .i_row_end,
        .o_valid, .i_ready, .o_result, .o_out_col, .o_row_last, .o_saturated,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    lrmb_checker u_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_func, .i_elem_index,
        .i_rank_index, .i_value, .i_row_end,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_result(o_result),
        .i_out_col(o_out_col), .i_row_last(o_row_last), .i_saturated(o_saturated),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // result side: random back-pressure, or a long hold when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog: any transaction on either channel or the register port restarts it
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("tb_low_rank_matmul_bias: errors");
            $finish;
        end
    end

    // q4.12 operand, weighted toward the extremes and zero
    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one input transaction; valid stays high afterwards, so every caller
    // either sends again or parks the input in the same step
    task automatic send_item(t_func f, int ix, int r, logic [15:0] v, bit last);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= f;
        i_elem_index <= ix[IDX_W-1:0];
        i_rank_index <= r[RANK_W-1:0];
        i_value      <= v;
        i_row_end    <= last;
        do @(posedge i_clk); while (!o_ready);
        n_items++;
    endtask

    // park the input and wait until every predicted column has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (ROW_SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(int din, int rank, int dout, int bias);
        drain();
        reg_write(REG_DIM_IN, din);
        reg_write(REG_RANK, rank);
        reg_write(REG_DIM_OUT, dout);
        reg_write(REG_BIAS_EN, bias);
        n_settings++;
    endtask

    // one x row of len elements, mostly inside dim_in, with table rewrites mixed in
    task automatic send_row(int len, int din);
        int pos;
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(9) == 0)
                send_item(t_func'($urandom_range(2)), $urandom_range(63),
                          $urandom_range(15), pick_value(), $urandom_range(1));
            if (din == 0 || $urandom_range(9) == 0)
                pos = $urandom_range(63);
            else
                pos = $urandom_range((din > 64 ? 64 : din) - 1);
            send_item(FUNC_X, pos, 0, pick_value(), j == len - 1);
        end
    endtask

    task automatic random_phase(int din, int rank, int dout, int bias, int items);
        int start;
        configure(din, rank, dout, bias);
        start = n_items;
        while (n_items - start < items)
            send_row($urandom_range(1, 8), din);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the entries that the rows below read: u rows and v columns
        // 0..7 at ranks 0..3, bias columns 0..7
        for (int j = 0; j < 8; j++)
            for (int r = 0; r < 4; r++)
                send_item(FUNC_WR_U, j, r, pick_value(), 1'b0);
        for (int c = 0; c < 8; c++)
            for (int r = 0; r < 4; r++)
                send_item(FUNC_WR_V, c, r, pick_value(), 1'b0);
        for (int c = 0; c < 8; c++)
            send_item(FUNC_WR_BIAS, c, 0, pick_value(), c[0]);
        // full rank at u row 0 and v column 0, all at the negative extreme
        for (int r = 0; r < K_MAX; r++) begin
            send_item(FUNC_WR_U, 0, r, 16'h8000, 1'b0);
            send_item(FUNC_WR_V, 0, r, 16'h8000, 1'b0);
        end

        // directed: extreme x rows, row end on table writes,
        // positions past dim_in that still close the row
        configure(4, 4, 8, 1);
        send_item(FUNC_X, 0, 0, 16'h8000, 1'b0);
        send_item(FUNC_X, 63, 0, 16'h8000, 1'b1);
        send_item(FUNC_X, 5, 0, 16'h7FFF, 1'b1);
        send_item(FUNC_WR_U, 63, 15, 16'h7FFF, 1'b1);
        send_item(FUNC_X, 3, 0, 16'h8000, 1'b0);
        send_item(FUNC_X, 63, 0, 16'h1234, 1'b1);
        send_item(FUNC_WR_BIAS, 0, 0, 16'h7FFF, 1'b1);
        send_item(FUNC_X, 0, 0, 16'h0000, 1'b1);
        configure(1, 1, 1, 1);
        send_item(FUNC_X, 0, 0, 16'h7FFF, 1'b1);
        send_item(FUNC_X, 1, 0, 16'h7FFF, 1'b1);
        configure(0, 0, 0, 0);
        send_item(FUNC_X, 0, 0, 16'h8000, 1'b1);
        // dim_in above every index and clamped rank, a long row at position 0 that drives the result to clip
        configure(127, 31, 1, 1);
        for (int j = 0; j < 72; j++)
            send_item(FUNC_X, 0, 0, 16'h8000, j == 71);
        // rank zero with the column count clamped: a full row of zero results
        configure(64, 0, 127, 0);
        send_item(FUNC_X, 10, 0, 16'h4000, 1'b1);

        random_phase(8, 4, 8, 1, 25);
        random_phase(7, 3, 5, 0, 25);
        tx_idle_pct = 45;
        rx_idle_pct = 11;
        random_phase(1, 1, 1, 1, 25);
        random_phase(5, 2, 8, 1, 25);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long result stall while items keep coming, until the block backs up
        configure(8, 4, 8, 0);
        hold_left = LONG_HOLD;
        for (int j = 0; j < 6; j++)
            send_row(3, 8);
        random_phase(6, 4, 6, 0, 25);
        random_phase(8, 4, 3, 1, 25);

        drain();
        $display("covered %0d input transactions, %0d results, %0d register settings",
                 n_items, result_count, n_settings);
        if (fail_count == 0 && pending == 0)
            $display("tb_low_rank_matmul_bias: clean");
        else
            $display("tb_low_rank_matmul_bias: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lrmb_pkg.sv
rtl/lrmb_front.sv
rtl/lrmb_back.sv
rtl/low_rank_matmul_bias.sv
dv/lrmb_checker.sv
dv/tb_low_rank_matmul_bias.sv
